### rtl/rc_autorange_setpoint_integrator_core_macros.svh
// ----------------------------------------------------------------------------
// rc_autorange_setpoint_integrator_core_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef RC_AUTORANGE_SETPOINT_INTEGRATOR_CORE_MACROS_SVH
`define RC_AUTORANGE_SETPOINT_INTEGRATOR_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define RCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/rca_pkg.sv
// ----------------------------------------------------------------------------
// rca_pkg
// Types and constants of the auto-ranging setpoint integrator.
// ----------------------------------------------------------------------------
package rca_pkg;
	localparam int NCH = 4;
	localparam logic [1:0] CMD_RESTART = 2'd0;
	localparam logic [1:0] CMD_CAL     = 2'd1;
	localparam logic [1:0] CMD_FLIGHT  = 2'd2;
	localparam logic CFG_YAW_GAIN = 1'b0;
	localparam logic CFG_POS_GAIN = 1'b1;
	localparam logic [15:0] YAW_GAIN_RST = 16'd655;
	localparam logic [15:0] POS_GAIN_RST = 16'd6554;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] sample_ch0;
		logic [15:0] sample_ch1;
		logic [15:0] sample_ch2;
		logic [15:0] sample_ch3;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] yaw_setpoint;
		logic signed [31:0] x_setpoint;
		logic signed [31:0] y_setpoint;
		logic [30:0]        z_setpoint;
		logic               limits_changed;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2, ST_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'(SAT_MAX)) return SAT_MAX;
		if (v < 50'(SAT_MIN)) return SAT_MIN;
		return v[31:0];
	endfunction
endpackage

### rtl/rc_autorange_setpoint_integrator_core.sv
// ----------------------------------------------------------------------------
// rc_autorange_setpoint_integrator_core
// Auto-ranging normalizer of four RC channels feeding four setpoint integrators.
// ----------------------------------------------------------------------------
// One item is handled at a time. Restarts, unknown commands and calibration
// samples that move no limit go straight to storing their result. A sample
// that moves a limit runs a bit-serial restoring divider, one quotient bit per
// cycle over a 50-bit dividend plus a load and a store step, twice per channel
// (scale, then offset) over all four channels. Flight samples then run a
// shift-add multiplier, one multiplier bit per cycle plus a load and a store
// step, twice per channel (scale by sample, gain by normalized value). The
// result waits in an output register; the next item may be taken while it
// waits, and its own result is stored only once that register is free.
module rc_autorange_setpoint_integrator_core #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rca_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rca_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int SB = SAMPLE_BITS;
	localparam int DW = 50;                      // dividend magnitude width
	localparam logic [SB-1:0] FULL = {SB{1'b1}};

	rca_pkg::state_t st_q, st_d;
	logic [15:0] yaw_gain_q, pos_gain_q;
	logic [SB-1:0] up_q [rca_pkg::NCH];
	logic [SB-1:0] lo_q [rca_pkg::NCH];
	logic signed [31:0] scale_q [rca_pkg::NCH];
	logic signed [31:0] offs_q [rca_pkg::NCH];
	logic signed [31:0] acc_q [rca_pkg::NCH];    // indexed by channel
	logic [SB-1:0] smp_q [rca_pkg::NCH];
	logic [1:0] cmd_q;
	logic chg_q;
	logic [1:0] ch_q;
	logic phase_q;                               // 0 scale / 1 offset
	logic [5:0] bit_q;
	// serial divider
	logic [DW-1:0] rem_q, quo_q;
	logic [SB:0] dmag_q;
	logic neg_q;
	// serial multiplier
	logic signed [49:0] prod_q;
	logic [49:0] mcand_q;
	logic [31:0] mplier_q;
	logic mneg_q;
	logic signed [31:0] norm_q;
	logic ovalid_q;
	rca_pkg::out_item_t out_q;

	assign in_ready = (st_q == rca_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign out_data = out_q;

	logic acc_in;
	assign acc_in = in_valid && in_ready;

	logic out_free;
	assign out_free = !ovalid_q || out_ready;

	// Incoming samples and whether any of them moves a limit.
	logic [SB-1:0] smp_in [rca_pkg::NCH];
	logic lim_move, is_smp;
	assign is_smp = (in_data.cmd == rca_pkg::CMD_CAL) || (in_data.cmd == rca_pkg::CMD_FLIGHT);
	always_comb begin
		smp_in[0] = in_data.sample_ch0[SB-1:0];
		smp_in[1] = in_data.sample_ch1[SB-1:0];
		smp_in[2] = in_data.sample_ch2[SB-1:0];
		smp_in[3] = in_data.sample_ch3[SB-1:0];
		lim_move = 1'b0;
		for (int i = 0; i < rca_pkg::NCH; i++)
			if (smp_in[i] > up_q[i] || smp_in[i] < lo_q[i]) lim_move = 1'b1;
	end

	// Operands of the current channel.
	logic signed [SB+1:0] diff, sum;
	assign diff = $signed({2'b00, up_q[ch_q]}) - $signed({2'b00, lo_q[ch_q]});
	assign sum  = $signed({2'b00, up_q[ch_q]}) + $signed({2'b00, lo_q[ch_q]});

	// Dividend magnitude and sign for each phase.
	logic [DW-1:0] num_mag;
	logic num_neg;
	always_comb begin
		if (!phase_q) begin
			num_mag = DW'(1) << (17 + SB);
			num_neg = 1'b0;
		end else begin
			num_mag = DW'(sum) << 16;
			num_neg = 1'b1;
		end
	end

	// Signed quotient from magnitude, saturated when it is stored.
	logic signed [49:0] quo_s;
	assign quo_s = (neg_q) ? -$signed(quo_q) : $signed(quo_q);

	logic [DW:0] trial;
	assign trial = {rem_q, quo_q[DW-1]} - {{(DW-SB){1'b0}}, dmag_q};

	logic gain_sel;
	assign gain_sel = (ch_q == 2'd3);
	logic [15:0] gain;
	assign gain = gain_sel ? yaw_gain_q : pos_gain_q;

	// Normalized value and increment, both saturated.
	logic signed [49:0] prod_t;
	assign prod_t = mneg_q ? -prod_q : prod_q;
	logic signed [31:0] norm_v, inc_v, acc_new;
	assign norm_v = rca_pkg::sat32((prod_t >>> SB) + ((prod_t < 0 && prod_t[SB-1:0] != '0)
		? 50'sd1 : 50'sd0) + 50'(offs_q[ch_q]));
	assign inc_v = rca_pkg::sat32((prod_t >>> 16) + ((prod_t < 0 && prod_t[15:0] != '0)
		? 50'sd1 : 50'sd0));
	always_comb begin
		acc_new = rca_pkg::sat32(50'(acc_q[ch_q]) + 50'(inc_v));
		if (ch_q == 2'd2 && acc_new < 0) acc_new = '0;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			rca_pkg::ST_IDLE: if (acc_in) begin
				if (is_smp && lim_move) st_d = rca_pkg::ST_DIV;
				else if (in_data.cmd == rca_pkg::CMD_FLIGHT) st_d = rca_pkg::ST_MUL1;
				else st_d = rca_pkg::ST_DONE;
			end
			rca_pkg::ST_DIV:  if (bit_q == 6'(DW + 1)) begin
				if (phase_q && ch_q == 2'd3)
					st_d = (cmd_q == rca_pkg::CMD_FLIGHT) ? rca_pkg::ST_MUL1 : rca_pkg::ST_DONE;
			end
			rca_pkg::ST_MUL1: if (bit_q == 6'(SB + 1)) st_d = rca_pkg::ST_MUL2;
			rca_pkg::ST_MUL2: if (bit_q == 6'd17)
				st_d = (ch_q == 2'd3) ? rca_pkg::ST_DONE : rca_pkg::ST_MUL1;
			rca_pkg::ST_DONE: if (out_free) st_d = rca_pkg::ST_IDLE;
			default: st_d = rca_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rca_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
			out_q <= '0;
			chg_q <= 1'b0;
			ch_q <= '0;
			phase_q <= 1'b0;
			bit_q <= '0;
			yaw_gain_q <= rca_pkg::YAW_GAIN_RST;
			pos_gain_q <= rca_pkg::POS_GAIN_RST;
			for (int i = 0; i < rca_pkg::NCH; i++) begin
				up_q[i] <= '0;
				lo_q[i] <= FULL;
				scale_q[i] <= '0;
				offs_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (cfg_valid) begin
				if (cfg_index == rca_pkg::CFG_YAW_GAIN) yaw_gain_q <= cfg_data;
				else pos_gain_q <= cfg_data;
			end
			if (st_q == rca_pkg::ST_DONE && out_free) ovalid_q <= 1'b1;
			else if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				rca_pkg::ST_IDLE: if (acc_in) begin
					cmd_q <= in_data.cmd;
					for (int i = 0; i < rca_pkg::NCH; i++) smp_q[i] <= smp_in[i];
					ch_q <= '0;
					phase_q <= 1'b0;
					bit_q <= '0;
					if (in_data.cmd == rca_pkg::CMD_RESTART) begin
						for (int i = 0; i < rca_pkg::NCH; i++) begin
							up_q[i] <= '0;
							lo_q[i] <= FULL;
						end
					end else if (is_smp) begin
						for (int i = 0; i < rca_pkg::NCH; i++) begin
							if (smp_in[i] > up_q[i]) up_q[i] <= smp_in[i];
							else if (smp_in[i] < lo_q[i]) lo_q[i] <= smp_in[i];
						end
					end
					chg_q <= is_smp && lim_move;
				end
				rca_pkg::ST_DIV: begin
					if (bit_q == '0) begin
						// Load the dividend and divisor magnitudes.
						rem_q <= '0;
						quo_q <= num_mag;
						dmag_q <= diff[SB+1] ? (SB+1)'(0) - diff[SB:0] : diff[SB:0];
						neg_q <= num_neg ^ diff[SB+1];
						bit_q <= 6'd1;
					end else if (bit_q <= 6'(DW)) begin
						if (!trial[DW]) begin
							rem_q <= trial[DW-1:0];
							quo_q <= {quo_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
							quo_q <= {quo_q[DW-2:0], 1'b0};
						end
						bit_q <= bit_q + 6'd1;
					end else begin
						logic signed [31:0] r;
						if (diff == '0) r = phase_q ? -32'sd65536 : 32'sd131072;
						else r = rca_pkg::sat32(quo_s);
						if (!phase_q) scale_q[ch_q] <= r;
						else begin
							offs_q[ch_q] <= r;
							ch_q <= ch_q + 2'd1;
						end
						phase_q <= !phase_q;
						bit_q <= '0;
					end
				end
				rca_pkg::ST_MUL1: begin
					if (bit_q == '0) begin
						prod_q <= '0;
						mcand_q <= 50'($unsigned(scale_q[ch_q][31] ? -scale_q[ch_q]
							: scale_q[ch_q]));
						mneg_q <= scale_q[ch_q][31];
						mplier_q <= 32'(smp_q[ch_q]);
						bit_q <= 6'd1;
					end else if (bit_q <= 6'(SB)) begin
						if (mplier_q[0]) prod_q <= prod_q + $signed(mcand_q);
						mcand_q <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
						bit_q <= bit_q + 6'd1;
					end else begin
						norm_q <= norm_v;
						bit_q <= '0;
					end
				end
				rca_pkg::ST_MUL2: begin
					if (bit_q == '0) begin
						prod_q <= '0;
						mcand_q <= 50'($unsigned(norm_q[31] ? -norm_q : norm_q));
						mneg_q <= norm_q[31];
						mplier_q <= 32'(gain);
						bit_q <= 6'd1;
					end else if (bit_q <= 6'd16) begin
						if (mplier_q[0]) prod_q <= prod_q + $signed(mcand_q);
						mcand_q <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
						bit_q <= bit_q + 6'd1;
					end else begin
						acc_q[ch_q] <= acc_new;
						ch_q <= ch_q + 2'd1;
						bit_q <= '0;
					end
				end
				rca_pkg::ST_DONE: if (out_free) begin
					out_q.yaw_setpoint <= acc_q[3];
					out_q.x_setpoint <= acc_q[1];
					out_q.y_setpoint <= acc_q[0];
					out_q.z_setpoint <= acc_q[2][30:0];
					out_q.limits_changed <= chg_q;
				end
				default: ;
			endcase
		end
	end
endmodule

### rtl/rca_checker.sv
// ----------------------------------------------------------------------------
// rca_checker
// Port-level checks of the setpoint integrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rc_autorange_setpoint_integrator_core_macros.svh"
module rca_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rca_pkg::out_item_t out_data
);
	// A result stays until its transfer.
	`RCA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	// A waiting result keeps its payload.
	`RCA_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data), "result changed")
	// An accepted item leaves the input closed next cycle.
	`RCA_ASSERT_NXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "input not closed")
	// An idle block stays open while nothing arrives.
	`RCA_ASSERT_NXT(a_idle_ready, clk, arst_n, in_ready && !in_valid, in_ready, "input closed while idle")
endmodule

bind rc_autorange_setpoint_integrator_core rca_checker u_rca_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### bench/rc_autorange_setpoint_integrator_core_test.sv
// ----------------------------------------------------------------------------
// rc_autorange_setpoint_integrator_core_test
// Self-checking bench for the auto-ranging setpoint integrator. A queued
// driver sends calibration, flight, restart and unknown frames in random
// bursts, the receiver stalls on its own pattern, and every result frame is
// checked as a whole against a fixed-point prediction of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_autorange_setpoint_integrator_core_test;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int SETTLE_CYCLES  = 100;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rca_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rca_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = rca_pkg::CFG_YAW_GAIN;
	logic [15:0] cfg_data = '0;

	rc_autorange_setpoint_integrator_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow state of the block.
	logic [15:0] upper_q[rca_pkg::NCH];
	logic [15:0] lower_q[rca_pkg::NCH];
	logic signed [31:0] scale_q[rca_pkg::NCH];
	logic signed [31:0] offset_q[rca_pkg::NCH];
	logic signed [31:0] yaw_acc, x_acc, y_acc, z_acc;
	logic [15:0] yaw_gain_q, pos_gain_q;

	rca_pkg::in_item_t  frame_queue[$];
	rca_pkg::out_item_t pending_setpoints[$];
	int mismatches = 0;
	int idle_cycles = 0;
	logic in_took = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	function automatic logic signed [31:0] clip_q16(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] norm_channel(int ch, logic [15:0] smp);
		longint p;
		p = (longint'(scale_q[ch]) * longint'(smp)) / 65536;
		return clip_q16(p + longint'(offset_q[ch]));
	endfunction

	function automatic logic signed [31:0] add_step(logic signed [31:0] acc,
			logic [15:0] gain, logic signed [31:0] nrm);
		logic signed [31:0] inc;
		inc = clip_q16((longint'(gain) * longint'(nrm)) / 65536);
		return clip_q16(longint'(acc) + longint'(inc));
	endfunction

	function automatic rca_pkg::out_item_t predict_frame(rca_pkg::in_item_t it);
		logic [15:0] smp[rca_pkg::NCH];
		bit moved;
		longint d, s;
		rca_pkg::out_item_t r;
		moved = 0;
		smp[0] = it.sample_ch0;
		smp[1] = it.sample_ch1;
		smp[2] = it.sample_ch2;
		smp[3] = it.sample_ch3;
		if (it.cmd == rca_pkg::CMD_RESTART) begin
			for (int i = 0; i < rca_pkg::NCH; i++) begin
				upper_q[i] = 16'h0000;
				lower_q[i] = 16'hffff;
			end
		end else if (it.cmd == rca_pkg::CMD_CAL || it.cmd == rca_pkg::CMD_FLIGHT) begin
			for (int i = 0; i < rca_pkg::NCH; i++) begin
				if (smp[i] > upper_q[i]) begin
					upper_q[i] = smp[i];
					moved = 1;
				end else if (smp[i] < lower_q[i]) begin
					lower_q[i] = smp[i];
					moved = 1;
				end
			end
			if (moved) begin
				for (int i = 0; i < rca_pkg::NCH; i++) begin
					d = longint'(upper_q[i]) - longint'(lower_q[i]);
					s = longint'(upper_q[i]) + longint'(lower_q[i]);
					if (d == 0) begin
						scale_q[i] = 32'sd131072;
						offset_q[i] = -32'sd65536;
					end else begin
						scale_q[i] = clip_q16(64'sd8589934592 / d);
						offset_q[i] = clip_q16(-(s * 65536) / d);
					end
				end
			end
			if (it.cmd == rca_pkg::CMD_FLIGHT) begin
				yaw_acc = add_step(yaw_acc, yaw_gain_q, norm_channel(3, smp[3]));
				x_acc = add_step(x_acc, pos_gain_q, norm_channel(1, smp[1]));
				y_acc = add_step(y_acc, pos_gain_q, norm_channel(0, smp[0]));
				z_acc = add_step(z_acc, pos_gain_q, norm_channel(2, smp[2]));
				if (z_acc < 0) z_acc = 0;
			end
		end
		r.yaw_setpoint = yaw_acc;
		r.x_setpoint = x_acc;
		r.y_setpoint = y_acc;
		r.z_setpoint = z_acc[30:0];
		r.limits_changed = moved;
		return r;
	endfunction

	// Monitor, predictor hook and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			in_took <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (pending_setpoints.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					if (out_data !== pending_setpoints[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p",
								pending_setpoints[0], out_data);
					end
					void'(pending_setpoints.pop_front());
				end
			end
			if (in_valid && in_ready)
				pending_setpoints.push_back(predict_frame(in_data));
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** rc_autorange_setpoint_integrator_core: FAILED **");
				$finish;
			end
		end
	end

	// Sender: bursts of frames with random gaps between them.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (frame_queue.size() > 0) begin
				in_data <= frame_queue.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: alternates between always ready, random, and long stalls.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 600);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				out_ready <= ($urandom_range(0, 99) < 3);
			end
		endcase
	end

	task automatic push_frame(logic [1:0] cmd, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [15:0] d);
		rca_pkg::in_item_t it;
		it.cmd = cmd;
		it.sample_ch0 = a;
		it.sample_ch1 = b;
		it.sample_ch2 = c;
		it.sample_ch3 = d;
		frame_queue.push_back(it);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'($urandom_range(0, 3));
			3: return 16'(32'h8000 + $urandom_range(0, 64) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_random(int n);
		int r;
		logic [1:0] cmd;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 4) cmd = rca_pkg::CMD_RESTART;
			else if (r < 34) cmd = rca_pkg::CMD_CAL;
			else if (r < 95) cmd = rca_pkg::CMD_FLIGHT;
			else cmd = CMD_UNKNOWN;
			push_frame(cmd, pick_sample(), pick_sample(), pick_sample(), pick_sample());
		end
	endtask

	task automatic drain();
		while (frame_queue.size() != 0 || in_valid || pending_setpoints.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(logic idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == rca_pkg::CFG_YAW_GAIN) yaw_gain_q = value;
		else pos_gain_q = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		for (int i = 0; i < rca_pkg::NCH; i++) begin
			upper_q[i] = 16'h0000;
			lower_q[i] = 16'hffff;
			scale_q[i] = 0;
			offset_q[i] = 0;
		end
		yaw_acc = 0;
		x_acc = 0;
		y_acc = 0;
		z_acc = 0;
		yaw_gain_q = rca_pkg::YAW_GAIN_RST;
		pos_gain_q = rca_pkg::POS_GAIN_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames at the default gains.
		push_frame(CMD_UNKNOWN, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		push_frame(rca_pkg::CMD_FLIGHT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_frame(rca_pkg::CMD_CAL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		push_frame(rca_pkg::CMD_CAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_frame(rca_pkg::CMD_FLIGHT, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
		push_frame(rca_pkg::CMD_FLIGHT, 16'h8000, 16'h7fff, 16'h8000, 16'h0001);
		push_frame(rca_pkg::CMD_CAL, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
		// Restart, then a zero sample leaves equal limits.
		push_frame(rca_pkg::CMD_RESTART, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		push_frame(rca_pkg::CMD_CAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_frame(rca_pkg::CMD_FLIGHT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// Restart, then a one: upper limit below lower limit.
		push_frame(rca_pkg::CMD_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_frame(rca_pkg::CMD_FLIGHT, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
		// A span of one gives a scale that saturates.
		push_frame(rca_pkg::CMD_FLIGHT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_frame(rca_pkg::CMD_FLIGHT, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
		push_frame(CMD_UNKNOWN, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		drain();

		write_gain(rca_pkg::CFG_YAW_GAIN, 16'hffff);
		write_gain(rca_pkg::CFG_POS_GAIN, 16'hffff);
		// Drive accumulators into saturation, and z down to its floor.
		for (int k = 0; k < 4; k++)
			push_frame(rca_pkg::CMD_FLIGHT, 16'h0001, 16'h0001, 16'h0000, 16'h0001);
		for (int k = 0; k < 4; k++)
			push_frame(rca_pkg::CMD_FLIGHT, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
		push_random(280);
		drain();

		write_gain(rca_pkg::CFG_YAW_GAIN, 16'h0000);
		write_gain(rca_pkg::CFG_POS_GAIN, 16'h0000);
		push_random(280);
		drain();

		write_gain(rca_pkg::CFG_YAW_GAIN, 16'($urandom));
		write_gain(rca_pkg::CFG_POS_GAIN, 16'($urandom));
		push_random(300);
		drain();

		write_gain(rca_pkg::CFG_YAW_GAIN, 16'hffff);
		write_gain(rca_pkg::CFG_POS_GAIN, 16'h0001);
		push_random(300);
		drain();

		write_gain(rca_pkg::CFG_YAW_GAIN, rca_pkg::YAW_GAIN_RST);
		write_gain(rca_pkg::CFG_POS_GAIN, rca_pkg::POS_GAIN_RST);
		push_random(300);
		drain();

		write_gain(rca_pkg::CFG_YAW_GAIN, 16'($urandom));
		write_gain(rca_pkg::CFG_POS_GAIN, 16'($urandom));
		push_random(290);
		drain();

		if (mismatches == 0)
			$display("** rc_autorange_setpoint_integrator_core: PASSED **");
		else
			$display("** rc_autorange_setpoint_integrator_core: FAILED **");
		$finish;
	end
endmodule
